// ----- sv/rslr_pkg.sv -----
// Shared constants and types of the sprite light remap block.
`timescale 1ns / 1ps
package rslr_pkg;

	localparam int ROW_PIXELS   = 32;
	localparam int ROW_COUNT    = 32;
	localparam int LIGHT_LEVELS = 16;

	localparam int LEVEL_W = 4;
	localparam int BYTE_W  = 8;
	localparam int ADDR_W  = LEVEL_W + BYTE_W;
	localparam int TABLE_DEPTH = 1 << ADDR_W;

	// Counter widths follow the row geometry.
	localparam int RPW = $clog2(ROW_PIXELS + 1);
	localparam int RCW = $clog2(ROW_COUNT + 1);
	// Common width for comparing a run count against the pixels left.
	localparam int CMPW = ((RPW > BYTE_W) ? RPW : BYTE_W) + 1;

	localparam logic SKIP_BIT_POS = 1'b1;
	localparam int   SKIP_BIT     = BYTE_W - 1;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_FRAME = 1'b1;

	// Result of one frame byte, before the table read completes.
	typedef struct packed {
		logic [BYTE_W-1:0] raw_byte;
		logic              use_remap;
		logic              is_header;
		logic              frame_end;
		logic              format_error;
	} res_t;

endpackage

// ----- sv/rslr_table.sv -----
// Colour table store: one write port, one registered read port.
`timescale 1ns / 1ps
module rslr_table
	import rslr_pkg::*;
(
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [BYTE_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [BYTE_W-1:0] rd_data
);

	logic [BYTE_W-1:0] mem [TABLE_DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- sv/rslr_ctrl.sv -----
// Frame parser: row and run counters, per-byte result decision, table address.
`timescale 1ns / 1ps
module rslr_ctrl
	import rslr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               frame_acc,
	input  logic [BYTE_W-1:0]  data_byte,
	input  logic [LEVEL_W-1:0] light_level,
	input  logic               frame_start,
	input  logic               frame_is_rle,
	input  logic               last_byte,
	output res_t               res,
	output logic [ADDR_W-1:0]  rd_addr
);

	logic [RPW-1:0]     literal_left_q, row_left_q;
	logic [RCW-1:0]     rows_left_q;
	logic [LEVEL_W-1:0] level_q;
	logic               rle_q;

	logic [RPW-1:0]     cur_lit, cur_row, nxt_lit, nxt_row;
	logic [RCW-1:0]     cur_rows, nxt_rows;
	logic [LEVEL_W-1:0] cur_level, lvl_sat;
	logic               cur_rle;
	logic [BYTE_W-1:0]  skip_cnt;
	logic [CMPW-1:0]    take_n;
	logic               take_en, take_all;

	always_comb begin
		lvl_sat = ({1'b0, light_level} >= (LEVEL_W+1)'(LIGHT_LEVELS))
			? LEVEL_W'(LIGHT_LEVELS - 1) : light_level;
		cur_level = frame_start ? lvl_sat      : level_q;
		cur_rle   = frame_start ? frame_is_rle : rle_q;
		cur_lit   = frame_start ? '0           : literal_left_q;
		cur_row   = frame_start ? RPW'(ROW_PIXELS) : row_left_q;
		cur_rows  = frame_start ? RCW'(ROW_COUNT)  : rows_left_q;
		skip_cnt  = ~data_byte + BYTE_W'(1);
	end

	assign rd_addr = {cur_level, data_byte};

	always_comb begin
		res.raw_byte     = data_byte;
		res.use_remap    = 1'b0;
		res.is_header    = 1'b0;
		res.frame_end    = 1'b0;
		res.format_error = 1'b0;
		nxt_lit  = cur_lit;
		nxt_row  = cur_row;
		nxt_rows = cur_rows;
		take_en  = 1'b0;
		take_n   = '0;
		if (cur_rows == '0) begin
			res.format_error = 1'b1;
		end else if (!cur_rle) begin
			res.use_remap = 1'b1;
			if (last_byte) begin
				res.frame_end = 1'b1;
				nxt_rows      = '0;
			end
		end else if (cur_lit != '0) begin
			res.use_remap = 1'b1;
			nxt_lit       = cur_lit - RPW'(1);
			take_en       = 1'b1;
			take_n        = CMPW'(1);
		end else if (data_byte[SKIP_BIT] == SKIP_BIT_POS) begin
			res.is_header = 1'b1;
			take_en       = 1'b1;
			take_n        = CMPW'(skip_cnt);
			if (CMPW'(skip_cnt) > CMPW'(cur_row)) begin
				res.format_error = 1'b1;
			end
		end else begin
			res.is_header = 1'b1;
			if (CMPW'(data_byte) > CMPW'(cur_row)) begin
				res.format_error = 1'b1;
				nxt_lit          = cur_row;
			end else begin
				nxt_lit = RPW'(data_byte);
			end
		end
		// Consume pixels of the current row; close the row when used up.
		take_all = take_en && (take_n >= CMPW'(cur_row));
		if (take_all) begin
			nxt_row  = RPW'(ROW_PIXELS);
			nxt_lit  = '0;
			nxt_rows = cur_rows - RCW'(1);
			res.frame_end = (cur_rows == RCW'(1));
		end else if (take_en) begin
			nxt_row = cur_row - RPW'(take_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			literal_left_q <= '0;
			row_left_q     <= RPW'(ROW_PIXELS);
			rows_left_q    <= '0;
			level_q        <= '0;
			rle_q          <= 1'b0;
		end else if (frame_acc) begin
			literal_left_q <= nxt_lit;
			row_left_q     <= nxt_row;
			rows_left_q    <= nxt_rows;
			level_q        <= cur_level;
			rle_q          <= cur_rle;
		end
	end

endmodule

// ----- sv/rle_sprite_light_remap_top.sv -----
// Top level of the sprite light remap block: stream ports, table, parser, output stage.
`timescale 1ns / 1ps
// A frame byte accepted on the slave side passes the table read (s1) and then the
// output register before it is offered on the master side.
// Throughput: one item per clock; the slave side stalls only while both stages hold
// a result and m_tready is low. Table writes produce no transfer on the master side.
// Reset (arst_n low) clears the frame counters and pipeline valids; no frame is
// active afterwards. The colour table is not cleared and needs no clearing pass.
module rle_sprite_light_remap_top
	import rslr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [11:0] table_addr, [19:12] data_byte, [23:20] light_level,
	// [24] frame_start, [25] frame_is_rle, [31:26] zero
	input  logic [31:0] s_tdata,
	// [0] op
	input  logic        s_tuser,
	input  logic        s_tlast,      // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] out_byte
	output logic [7:0]  m_tdata,
	// [0] is_header, [1] format_error
	output logic [1:0]  m_tuser,
	output logic        m_tlast       // frame_end
);

	// Input field split.
	logic [ADDR_W-1:0]  in_addr;
	logic [BYTE_W-1:0]  in_byte;
	logic [LEVEL_W-1:0] in_level;
	logic               in_start, in_rle, in_acc, frame_acc, wr_acc;

	assign in_addr  = s_tdata[11:0];
	assign in_byte  = s_tdata[19:12];
	assign in_level = s_tdata[23:20];
	assign in_start = s_tdata[24];
	assign in_rle   = s_tdata[25];

	// Pipeline control: s1 holds a byte whose table read is in flight.
	logic valid_s1, adv_s1, out_valid_q;
	res_t res, res_s1;
	logic [ADDR_W-1:0] rd_addr;
	logic [BYTE_W-1:0] rd_data;

	assign adv_s1    = !out_valid_q || m_tready;
	assign s_tready  = !valid_s1 || adv_s1;
	assign in_acc    = s_tvalid && s_tready;
	assign frame_acc = in_acc && (s_tuser == OP_FRAME);
	assign wr_acc    = in_acc && (s_tuser == OP_WRITE);

	rslr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_acc    (frame_acc),
		.data_byte    (in_byte),
		.light_level  (in_level),
		.frame_start  (in_start),
		.frame_is_rle (in_rle),
		.last_byte    (s_tlast),
		.res          (res),
		.rd_addr      (rd_addr)
	);

	// Read only on a frame transfer, so the read data holds while s1 stalls.
	rslr_table u_table (
		.clk     (clk),
		.wr_en   (wr_acc),
		.wr_addr (in_addr),
		.wr_data (in_byte),
		.rd_en   (frame_acc),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= frame_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_acc) begin
			res_s1 <= res;
		end
	end

	// Output register: advance when empty or when the current result transfers.
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_hdr_q, out_end_q, out_err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			out_byte_q <= res_s1.use_remap ? rd_data : res_s1.raw_byte;
			out_hdr_q  <= res_s1.is_header;
			out_end_q  <= res_s1.frame_end;
			out_err_q  <= res_s1.format_error;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = {out_err_q, out_hdr_q};
	assign m_tlast  = out_end_q;

endmodule
